// File: sv/scdp_pkg.sv
package scdp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int ENERGY_W   = 8;
	localparam int COST_W     = 18;
	localparam int STEP_W     = 2;
	localparam int OUT_COL_W  = 10;
	localparam int OUT_DATA_W = 40;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd1;

	localparam logic signed [STEP_W-1:0] STEP_LEFT   = -2'sd1;
	localparam logic signed [STEP_W-1:0] STEP_CENTRE = 2'sd0;
	localparam logic signed [STEP_W-1:0] STEP_RIGHT  = 2'sd1;

	typedef struct packed {
		logic first_row;
		logic has_left;
		logic has_right;
	} cell_ctl_t;

	typedef struct packed {
		logic [COST_W-1:0]        cost;
		logic signed [STEP_W-1:0] step;
	} cell_res_t;

endpackage

// File: sv/scdp_line_ram.sv
module scdp_line_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [scdp_pkg::COL_W-1:0]   waddr,
	input  logic [scdp_pkg::COST_W-1:0]  wdata,
	input  logic                         re,
	input  logic [scdp_pkg::COL_W-1:0]   raddr0,
	input  logic [scdp_pkg::COL_W-1:0]   raddr1,
	output logic [scdp_pkg::COST_W-1:0]  rdata0,
	output logic [scdp_pkg::COST_W-1:0]  rdata1
);

	logic [scdp_pkg::COST_W-1:0] mem [scdp_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-through: a read of the entry being written sees the new value
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
			rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
		end
	end

endmodule

// File: sv/scdp_cost_cell.sv
module scdp_cost_cell (
	input  logic [scdp_pkg::ENERGY_W-1:0] energy,
	input  scdp_pkg::cell_ctl_t           ctl,
	input  logic [scdp_pkg::COST_W-1:0]   up_l,
	input  logic [scdp_pkg::COST_W-1:0]   up_c,
	input  logic [scdp_pkg::COST_W-1:0]   up_r,
	output scdp_pkg::cell_res_t           res
);

	// one extra bit so an outside column is above any stored cost
	logic [scdp_pkg::COST_W:0] a, b, c, m;
	logic [scdp_pkg::COST_W:0] sum;
	logic signed [scdp_pkg::STEP_W-1:0] step;

	always_comb begin
		a = ctl.has_left  ? {1'b0, up_l} : {1'b1, {scdp_pkg::COST_W{1'b0}}};
		b = {1'b0, up_c};
		c = ctl.has_right ? {1'b0, up_r} : {1'b1, {scdp_pkg::COST_W{1'b0}}};
		if (a < b) begin
			if (a < c) begin
				m = a;
				step = scdp_pkg::STEP_LEFT;
			end else begin
				m = c;
				step = scdp_pkg::STEP_RIGHT;
			end
		end else begin
			if (b < c) begin
				m = b;
				step = scdp_pkg::STEP_CENTRE;
			end else begin
				m = c;
				step = scdp_pkg::STEP_RIGHT;
			end
		end
		sum = m + {{(scdp_pkg::COST_W + 1 - scdp_pkg::ENERGY_W){1'b0}}, energy};
		if (ctl.first_row) begin
			res.cost = {{(scdp_pkg::COST_W - scdp_pkg::ENERGY_W){1'b0}}, energy};
			res.step = scdp_pkg::STEP_CENTRE;
		end else begin
			res.cost = sum[scdp_pkg::COST_W] ? scdp_pkg::COST_MAX
				: sum[scdp_pkg::COST_W-1:0];
			res.step = step;
		end
	end

endmodule

// File: sv/seam_cost_dp_row_stream_top.sv
// Registered path from input request to result: input stage, then result register.
// Throughput: one pixel per cycle while m_tready does not stall; the line store reads the two upper
// neighbours at input time and writes the new cost as the pixel leaves stage 1.
// Reset (arst_n low, asynchronous): row_width and row_count return to 1024,
// the frame restarts at row 0 column 0, both stages empty. Line store not cleared.
module seam_cost_dp_row_stream_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scdp_pkg::ENERGY_W-1:0]     s_tdata,   // [7:0] energy
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [9:0] column, [27:10] cum_cost, [29:28] back_step, [39:30] seam_end_col
	output logic [scdp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast,   // frame_end
	input  logic                              cfg_we,
	input  logic [scdp_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [scdp_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam logic [scdp_pkg::CFG_W-1:0] W_MAX = scdp_pkg::CFG_W'(scdp_pkg::MAX_WIDTH);
	localparam logic [scdp_pkg::CFG_W-1:0] H_MAX = scdp_pkg::CFG_W'(scdp_pkg::MAX_HEIGHT);
	localparam logic [scdp_pkg::CFG_W-1:0] ONE   = scdp_pkg::CFG_W'(1);

	logic [scdp_pkg::CFG_W-1:0] width_q, height_q;
	logic [scdp_pkg::CFG_W-1:0] cfg_w_clamp, cfg_h_clamp;
	logic [scdp_pkg::COL_W-1:0] col_q;
	logic [scdp_pkg::ROW_W-1:0] row_q;
	logic                       last_col, last_row;
	logic                       accept, adv;

	logic                                v_s1;
	logic [scdp_pkg::ENERGY_W-1:0]       energy_s1;
	logic [scdp_pkg::COL_W-1:0]          col_s1;
	scdp_pkg::cell_ctl_t                 ctl_s1;
	logic                                last_row_s1, last_col_s1;

	logic [scdp_pkg::COST_W-1:0] up_c, up_r, upleft_q;
	logic [scdp_pkg::COST_W-1:0] best_cost_q;
	logic [scdp_pkg::COL_W-1:0]  best_col_q;
	logic                        take_best;
	logic [scdp_pkg::COL_W-1:0]  best_col_new;
	scdp_pkg::cell_res_t         res;

	logic                               out_v_q;
	logic [scdp_pkg::OUT_COL_W-1:0]     col_q_out;
	logic [scdp_pkg::COST_W-1:0]        cost_q;
	logic signed [scdp_pkg::STEP_W-1:0] step_q;
	logic                               frame_end_q;
	logic [scdp_pkg::OUT_COL_W-1:0]     seam_col_q;

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	assign last_col = ({1'b0, col_q} + ONE) == width_q;
	assign last_row = ({1'b0, row_q} + ONE) == height_q;

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_w_clamp = ONE;
			cfg_h_clamp = ONE;
		end else begin
			cfg_w_clamp = (cfg_wdata > W_MAX) ? W_MAX : cfg_wdata;
			cfg_h_clamp = (cfg_wdata > H_MAX) ? H_MAX : cfg_wdata;
		end
	end

	// configuration and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_MAX;
			height_q <= H_MAX;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				scdp_pkg::REG_ROW_WIDTH: width_q  <= cfg_w_clamp;
				scdp_pkg::REG_ROW_COUNT: height_q <= cfg_h_clamp;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	scdp_line_ram u_line (
		.clk    (clk),
		.we     (adv),
		.waddr  (col_s1),
		.wdata  (res.cost),
		.re     (accept),
		.raddr0 (col_q),
		.raddr1 (col_q + 1'b1),
		.rdata0 (up_c),
		.rdata1 (up_r)
	);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			energy_s1           <= s_tdata;
			col_s1              <= col_q;
			ctl_s1.first_row    <= (row_q == '0);
			ctl_s1.has_left     <= (col_q != '0);
			ctl_s1.has_right    <= !last_col;
			last_row_s1         <= last_row;
			last_col_s1         <= last_col;
		end
	end

	scdp_cost_cell u_cell (
		.energy (energy_s1),
		.ctl    (ctl_s1),
		.up_l   (upleft_q),
		.up_c   (up_c),
		.up_r   (up_r),
		.res    (res)
	);

	// running minimum of the last row; column 0 always restarts it
	assign take_best    = last_row_s1 && (col_s1 == '0 || res.cost < best_cost_q);
	assign best_col_new = take_best ? col_s1 : best_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upleft_q    <= '0;
			best_cost_q <= scdp_pkg::COST_MAX;
			best_col_q  <= '0;
		end else if (adv) begin
			upleft_q <= last_col_s1 ? '0 : up_c;
			if (take_best) begin
				best_cost_q <= res.cost;
				best_col_q  <= col_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_q_out   <= scdp_pkg::OUT_COL_W'(col_s1);
			cost_q      <= res.cost;
			step_q      <= res.step;
			frame_end_q <= last_row_s1 && last_col_s1;
			seam_col_q  <= (last_row_s1 && last_col_s1)
				? scdp_pkg::OUT_COL_W'(best_col_new) : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = frame_end_q;
	assign m_tdata  = {seam_col_q, step_q, cost_q, col_q_out};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import scdp_pkg::*;

	localparam int COST_LSB = OUT_COL_W;
	localparam int STEP_LSB = COST_LSB + COST_W;
	localparam int SEAM_LSB = STEP_LSB + STEP_W;
	localparam bit [COST_W:0] COST_INF = {1'b1, {COST_W{1'b0}}};

	typedef struct {
		bit [OUT_COL_W-1:0]     column;
		bit [COST_W-1:0]        cum_cost;
		bit signed [STEP_W-1:0] back_step;
		bit                     frame_end;
		bit [OUT_COL_W-1:0]     seam_col;
	} pix_res_t;

	class seam_board;
		bit [CFG_W-1:0]    width_reg;
		bit [CFG_W-1:0]    count_reg;
		bit [COST_W-1:0]   line_cost [MAX_WIDTH];
		bit [COST_W-1:0]   upleft;
		bit [COST_W-1:0]   best_cost;
		bit [COL_W-1:0]    best_col;
		bit [COL_W-1:0]    col_pos;
		bit [ROW_W-1:0]    row_pos;
		pix_res_t          cost_due[$];
		int                errors;

		function new();
			width_reg = CFG_W'(MAX_WIDTH);
			count_reg = CFG_W'(MAX_HEIGHT);
			errors = 0;
			restart();
		endfunction

		function void restart();
			upleft = '0;
			col_pos = '0;
			row_pos = '0;
			best_cost = COST_MAX;
			best_col = '0;
		endfunction

		function int unsigned clamp_size(bit [CFG_W-1:0] v, int unsigned maxv);
			if (v == 0)
				return 1;
			if (v > maxv)
				return maxv;
			return v;
		endfunction

		// any register write restarts the frame
		function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
			if (idx == REG_ROW_WIDTH)
				width_reg = val;
			else
				count_reg = val;
			restart();
		endfunction

		function int due_count();
			return cost_due.size();
		endfunction

		function void note_pixel(bit [ENERGY_W-1:0] e);
			int unsigned w, h, x;
			bit [COST_W:0] a, b, c, m, sum;
			bit [COST_W-1:0] cost;
			bit signed [STEP_W-1:0] step;
			bit last_row;
			pix_res_t r;
			w = clamp_size(width_reg, MAX_WIDTH);
			h = clamp_size(count_reg, MAX_HEIGHT);
			x = col_pos;
			if (x >= w)
				x = 0;
			if (row_pos >= h)
				row_pos = '0;
			step = STEP_CENTRE;
			if (row_pos == 0) begin
				cost = COST_W'(e);
			end else begin
				a = (x > 0) ? {1'b0, upleft} : COST_INF;
				b = {1'b0, line_cost[x]};
				c = (x + 1 < w) ? {1'b0, line_cost[x + 1]} : COST_INF;
				// left only when strictly smallest; centre beats right only when strictly
				if (a < b) begin
					if (a < c) begin
						m = a;
						step = STEP_LEFT;
					end else begin
						m = c;
						step = STEP_RIGHT;
					end
				end else begin
					if (b < c) begin
						m = b;
						step = STEP_CENTRE;
					end else begin
						m = c;
						step = STEP_RIGHT;
					end
				end
				sum = m + (COST_W + 1)'(e);
				cost = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
			end
			upleft = line_cost[x];
			line_cost[x] = cost;
			last_row = (row_pos + 1 == h);
			if (last_row && (x == 0 || cost < best_cost)) begin
				best_cost = cost;
				best_col = COL_W'(x);
			end
			r.column = OUT_COL_W'(x);
			r.cum_cost = cost;
			r.back_step = step;
			r.frame_end = last_row && (x + 1 == w);
			r.seam_col = r.frame_end ? best_col : '0;
			cost_due.push_back(r);
			if (x + 1 == w) begin
				col_pos = '0;
				upleft = '0;
				if (last_row)
					restart();
				else
					row_pos = row_pos + 1'b1;
			end else begin
				col_pos = COL_W'(x + 1);
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d, logic last);
			pix_res_t want;
			logic [OUT_COL_W-1:0] col, seam;
			logic [COST_W-1:0] cost;
			logic signed [STEP_W-1:0] step;
			col = d[OUT_COL_W-1:0];
			cost = d[COST_LSB +: COST_W];
			step = d[STEP_LSB +: STEP_W];
			seam = d[SEAM_LSB +: OUT_COL_W];
			if (cost_due.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: column %0d cost %0d",
					$time, col, cost);
				return;
			end
			want = cost_due.pop_front();
			if (col !== want.column) begin
				errors++;
				$display("%0t: column expected %0d actual %0d", $time, want.column, col);
			end
			if (cost !== want.cum_cost) begin
				errors++;
				$display("%0t: cum_cost expected %0d actual %0d (column %0d)",
					$time, want.cum_cost, cost, want.column);
			end
			if (step !== want.back_step) begin
				errors++;
				$display("%0t: back_step expected %0d actual %0d (column %0d)",
					$time, want.back_step, step, want.column);
			end
			if (last !== want.frame_end) begin
				errors++;
				$display("%0t: frame_end expected %0b actual %0b (column %0d)",
					$time, want.frame_end, last, want.column);
			end
			if (seam !== want.seam_col) begin
				errors++;
				$display("%0t: seam_end_col expected %0d actual %0d",
					$time, want.seam_col, seam);
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [ENERGY_W-1:0]     s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tlast;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_addr = '0;
	logic [CFG_W-1:0]        cfg_wdata = '0;

	seam_board sb;
	bit calm = 1'b0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;

	seam_cost_dp_row_stream_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// result side: check every accepted result, stall at random or on a hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 31);
		end
	end

	function automatic bit [ENERGY_W-1:0] pick_energy(int mode);
		case (mode)
			0: return ENERGY_W'($urandom_range(0, 3));       // many ties
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: return ENERGY_W'(255 - $urandom_range(0, 7));
			default: return ENERGY_W'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input bit [ENERGY_W-1:0] e);
		while (!calm && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			s_tdata <= ENERGY_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= e;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(e);
	endtask

	task automatic drain_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_count() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic run_frames(input int n, input int mode);
		repeat (n) send_pixel(pick_energy(mode));
	endtask

	initial begin
		bit [ENERGY_W-1:0] frame3x4 [12];
		int rand_sent;
		int wv, hv, we, he, n;
		// 3 wide, 4 rows: equal ties, strict left, strict centre, tie in the last row
		frame3x4 = '{8'd5, 8'd5, 8'd5, 8'd0, 8'd0, 8'd0,
			8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes, row 0 passes energy through
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		send_pixel(8'h01);
		send_pixel(8'h80);
		drain_block();

		write_reg(REG_ROW_WIDTH, 11'd3);
		write_reg(REG_ROW_COUNT, 11'd4);
		foreach (frame3x4[i])
			send_pixel(frame3x4[i]);
		drain_block();

		// zero width acts as one column, oversized count acts as the maximum
		write_reg(REG_ROW_WIDTH, 11'd0);
		write_reg(REG_ROW_COUNT, 11'd2047);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd255);
		send_pixel(8'd7);
		send_pixel(8'd0);
		send_pixel(8'd128);
		send_pixel(8'd255);
		drain_block();

		// one column, 80 rows, no idling on either side
		calm = 1'b1;
		write_reg(REG_ROW_WIDTH, 11'd1);
		write_reg(REG_ROW_COUNT, 11'd80);
		run_frames(80, 2);
		drain_block();
		calm = 1'b0;

		// 64 wide, two rows; the sink holds off so the block backs up
		write_reg(REG_ROW_WIDTH, 11'd64);
		write_reg(REG_ROW_COUNT, 11'd2);
		hold_ask++;
		run_frames(128, 3);
		drain_block();

		// oversized width, zero count: part of a single-row frame
		write_reg(REG_ROW_WIDTH, 11'd2047);
		write_reg(REG_ROW_COUNT, 11'd0);
		run_frames(48, 0);
		drain_block();

		rand_sent = 0;
		while (rand_sent < 170) begin
			wv = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			hv = $urandom_range(1, 8);
			if ($urandom_range(0, 19) == 0)
				wv = 0;
			if ($urandom_range(0, 19) == 0)
				hv = 0;
			we = (wv == 0) ? 1 : wv;
			he = (hv == 0) ? 1 : hv;
			if ($urandom_range(0, 1)) begin
				write_reg(REG_ROW_WIDTH, CFG_W'(wv));
				write_reg(REG_ROW_COUNT, CFG_W'(hv));
			end else begin
				write_reg(REG_ROW_COUNT, CFG_W'(hv));
				write_reg(REG_ROW_WIDTH, CFG_W'(wv));
			end
			n = $urandom_range(1, 3) * we * he;
			// now and then cut a frame short before the next write
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			if (n > 170 - rand_sent)
				n = 170 - rand_sent;
			run_frames(n, $urandom_range(0, 5));
			rand_sent += n;
			drain_block();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.due_count() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
